// ===== hw/rtl/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// shared widths, register codes, structs and width helpers for the
// triangle coverage test
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int COL_W       = 10;
    localparam int STEP_W      = 15;
    localparam int VTX_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = COL_W + STEP_W;
    localparam int DIFF_W      = VTX_W + 1;
    localparam int VPROD_W     = 2 * VTX_W;
    localparam int K_W         = VPROD_W + 1;
    localparam int W_W         = K_W + 2;
    localparam int LANES       = 3;

    localparam int MAX_DIM_DEF = 1024;
    localparam int FRAC_DEF    = 14;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X    = 4'd0,
        REG_A_Y    = 4'd1,
        REG_B_X    = 4'd2,
        REG_B_Y    = 4'd3,
        REG_C_X    = 4'd4,
        REG_C_Y    = 4'd5,
        REG_X_STEP = 4'd6,
        REG_Y_STEP = 4'd7
    } tct_reg_e;

    typedef struct packed {
        logic signed [VTX_W-1:0]  ax;
        logic signed [VTX_W-1:0]  ay;
        logic signed [VTX_W-1:0]  bx;
        logic signed [VTX_W-1:0]  by;
        logic signed [VTX_W-1:0]  cx;
        logic signed [VTX_W-1:0]  cy;
        logic        [STEP_W-1:0] x_step;
        logic        [STEP_W-1:0] y_step;
    } tct_cfg_t;

    // pixel identity plus the bounds flag, carried down the pipeline
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic             in_range;
    } tct_tag_t;

    // width of a mapped pixel coordinate: the step product or the offset, plus sign
    function automatic int tct_pos_w(input int frac);
        int base;
        base = (PROD_W > frac + 1) ? PROD_W : frac + 1;
        return base + 1;
    endfunction

    // width of one edge-term product
    function automatic int tct_mul_w(input int frac);
        return tct_pos_w(frac) + DIFF_W;
    endfunction

    // width of a sub-area: three terms summed
    function automatic int tct_sum_w(input int frac);
        int m;
        m = (tct_mul_w(frac) > K_W) ? tct_mul_w(frac) : K_W;
        return m + 2;
    endfunction

endpackage

// ===== hw/rtl/tct_ifs.sv =====
// ----------------------------------------------------------------------------
// tct_ifs
// valid/ready channels of the triangle coverage test: pixel in, result out,
// configuration writes
// ----------------------------------------------------------------------------
interface tct_in_if import tct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pixel_col;
    logic [COL_W-1:0] pixel_row;

    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface tct_out_if import tct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [COL_W-1:0] out_row;
    logic             covered;

    modport source (output valid, out_col, out_row, covered, input ready);
    modport sink   (input valid, out_col, out_row, covered, output ready);
endinterface

interface tct_cfg_if import tct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/triangle_coverage_test.sv =====
// ----------------------------------------------------------------------------
// triangle_coverage_test
// per-pixel inside test against one configured triangle
// ----------------------------------------------------------------------------
// Each item is a pixel column and row; the block maps it to x = col*x_step - 1
// and y = row*y_step - 1 in signed fixed point with COORD_FRAC_BITS fraction
// bits, forms the three signed sub-areas exactly, and reports the pixel as
// covered when each sub-area is zero or shares the sign of the whole area and
// does not exceed it in magnitude. A zero-area triangle covers nothing, and a
// column or row at or beyond MAX_DIM is never covered. The datapath is a
// four-stage pipeline (coordinate multiply, edge-term multiply, three-input
// sum, compare into the output register): it takes one item per clock while
// the result side is ready, and each result is registered at the end of the
// fourth stage. No stage holds more than one multiplier layer; a stall on the
// result side holds every stage in place, and an empty stage keeps taking
// items. The user must write the vertex and step registers through the
// configuration channel only while no item is in flight; the block itself
// does not enforce this. They reset to a zero triangle with steps of 32.
// ----------------------------------------------------------------------------
module triangle_coverage_test import tct_pkg::*;
#(
    parameter int MAX_DIM         = MAX_DIM_DEF,
    parameter int COORD_FRAC_BITS = FRAC_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    tct_cfg_if.sink   cfg,
    tct_in_if.sink    pixel,
    tct_out_if.source result
);

    localparam int PW = tct_pos_w(COORD_FRAC_BITS);
    localparam int SW = tct_sum_w(COORD_FRAC_BITS);

    // configuration
    tct_cfg_t regs;

    // stage 1 to stage 2
    logic                      s1_valid, s1_ready;
    tct_tag_t                  s1_tag;
    logic signed [PW-1:0]      s1_px, s1_py;
    logic signed [DIFF_W-1:0]  s1_ex [LANES];
    logic signed [DIFF_W-1:0]  s1_ey [LANES];
    logic signed [VPROD_W-1:0] s1_pa [LANES];
    logic signed [VPROD_W-1:0] s1_pb [LANES];

    // stage 3 to stage 4
    logic                      s3_valid, s3_ready;
    tct_tag_t                  s3_tag;
    logic signed [SW-1:0]      s3_sub [LANES];
    logic signed [W_W-1:0]     s3_whole;

    tct_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // stage 1: coordinate mapping, edge deltas, vertex products
    tct_map #(
        .MAX_DIM         (MAX_DIM),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .regs      (regs),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .tag       (s1_tag),
        .px        (s1_px),
        .py        (s1_py),
        .ex        (s1_ex),
        .ey        (s1_ey),
        .pa        (s1_pa),
        .pb        (s1_pb)
    );

    // stages 2 and 3: edge terms and area sums
    tct_area #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_area
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_tag    (s1_tag),
        .px        (s1_px),
        .py        (s1_py),
        .ex        (s1_ex),
        .ey        (s1_ey),
        .pa        (s1_pa),
        .pb        (s1_pb),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_tag   (s3_tag),
        .sub       (s3_sub),
        .whole     (s3_whole)
    );

    // stage 4: range test and output register
    tct_decide #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_decide
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_valid),
        .in_ready (s3_ready),
        .in_tag   (s3_tag),
        .sub      (s3_sub),
        .whole    (s3_whole),
        .result   (result)
    );

`ifndef NO_ASSERTIONS
    // a free output side never blocks the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> pixel.ready)
        else $error("input stalled while result side is ready");

    // with the result side ready, an item comes out after the full pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(pixel.valid && pixel.ready, 3) && $past(rst_n, 3) && $past(rst_n, 2)
        && $past(rst_n, 1) && $past(result.ready, 2) && $past(result.ready, 1)
        && result.ready
        |=> result.valid && (result.out_col == $past(pixel.pixel_col, 4))
            && (result.out_row == $past(pixel.pixel_row, 4)))
        else $error("item lost or misaligned through the pipeline");

    // a covered pixel always lies inside the image bounds
    a_cov_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.covered
        |-> (int'(result.out_col) < MAX_DIM) && (int'(result.out_row) < MAX_DIM))
        else $error("covered pixel outside the image bounds");
`endif

endmodule

// ===== hw/rtl/tct_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tct_cfg_regs
// vertex and step registers, written through the configuration channel
// ----------------------------------------------------------------------------
module tct_cfg_regs import tct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tct_cfg_if.sink       cfg,
    output tct_cfg_t      regs
);

    tct_cfg_t regs_reg;
    tct_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_A_X:    regs_next.ax     = $signed(cfg.data[VTX_W-1:0]);
                REG_A_Y:    regs_next.ay     = $signed(cfg.data[VTX_W-1:0]);
                REG_B_X:    regs_next.bx     = $signed(cfg.data[VTX_W-1:0]);
                REG_B_Y:    regs_next.by     = $signed(cfg.data[VTX_W-1:0]);
                REG_C_X:    regs_next.cx     = $signed(cfg.data[VTX_W-1:0]);
                REG_C_Y:    regs_next.cy     = $signed(cfg.data[VTX_W-1:0]);
                REG_X_STEP: regs_next.x_step = cfg.data[STEP_W-1:0];
                REG_Y_STEP: regs_next.y_step = cfg.data[STEP_W-1:0];
                default:    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ax     <= '0;
            regs_reg.ay     <= '0;
            regs_reg.bx     <= '0;
            regs_reg.by     <= '0;
            regs_reg.cx     <= '0;
            regs_reg.cy     <= '0;
            regs_reg.x_step <= STEP_RESET;
            regs_reg.y_step <= STEP_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hw/rtl/tct_map.sv =====
// ----------------------------------------------------------------------------
// tct_map
// stage 1: pixel to normalized coordinates, edge deltas and vertex cross
// products
// ----------------------------------------------------------------------------
module tct_map import tct_pkg::*;
#(
    parameter int MAX_DIM         = MAX_DIM_DEF,
    parameter int COORD_FRAC_BITS = FRAC_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    tct_in_if.sink                                 pixel,
    input  tct_cfg_t                               regs,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output tct_tag_t                               tag,
    output logic signed [tct_pos_w(COORD_FRAC_BITS)-1:0] px,
    output logic signed [tct_pos_w(COORD_FRAC_BITS)-1:0] py,
    output logic signed [DIFF_W-1:0]               ex [LANES],
    output logic signed [DIFF_W-1:0]               ey [LANES],
    output logic signed [VPROD_W-1:0]              pa [LANES],
    output logic signed [VPROD_W-1:0]              pb [LANES]
);

    localparam int PW = tct_pos_w(COORD_FRAC_BITS);
    localparam logic [PW-1:0] ONE = PW'(1) << COORD_FRAC_BITS;

    logic                      v_reg;
    logic                      in_ready;
    logic                      load;
    logic [PROD_W-1:0]         prod_x;
    logic [PROD_W-1:0]         prod_y;
    logic signed [VTX_W-1:0]   ax, ay, bx, by, cx, cy;
    tct_tag_t                  tag_reg;
    logic signed [PW-1:0]      px_reg, py_reg;
    logic signed [DIFF_W-1:0]  ex_reg [LANES];
    logic signed [DIFF_W-1:0]  ey_reg [LANES];
    logic signed [VPROD_W-1:0] pa_reg [LANES];
    logic signed [VPROD_W-1:0] pb_reg [LANES];

    assign ax = $signed(regs.ax);
    assign ay = $signed(regs.ay);
    assign bx = $signed(regs.bx);
    assign by = $signed(regs.by);
    assign cx = $signed(regs.cx);
    assign cy = $signed(regs.cy);

    assign in_ready    = !v_reg || out_ready;
    assign pixel.ready = in_ready;
    assign load        = pixel.valid && in_ready;

    assign prod_x = pixel.pixel_col * regs.x_step;
    assign prod_y = pixel.pixel_row * regs.y_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg.col      <= pixel.pixel_col;
            tag_reg.row      <= pixel.pixel_row;
            tag_reg.in_range <= (int'(pixel.pixel_col) < MAX_DIM)
                             && (int'(pixel.pixel_row) < MAX_DIM);
            px_reg    <= $signed(PW'(prod_x) - ONE);
            py_reg    <= $signed(PW'(prod_y) - ONE);
            // edge deltas, one pair per sub-triangle
            ex_reg[0] <= DIFF_W'(by) - DIFF_W'(cy);
            ey_reg[0] <= DIFF_W'(cx) - DIFF_W'(bx);
            ex_reg[1] <= DIFF_W'(cy) - DIFF_W'(ay);
            ey_reg[1] <= DIFF_W'(ax) - DIFF_W'(cx);
            ex_reg[2] <= DIFF_W'(ay) - DIFF_W'(by);
            ey_reg[2] <= DIFF_W'(bx) - DIFF_W'(ax);
            // vertex-only cross products
            pa_reg[0] <= bx * cy;
            pb_reg[0] <= cx * by;
            pa_reg[1] <= cx * ay;
            pb_reg[1] <= ax * cy;
            pa_reg[2] <= ax * by;
            pb_reg[2] <= bx * ay;
        end
    end

    assign out_valid = v_reg;
    assign tag       = tag_reg;
    assign px        = px_reg;
    assign py        = py_reg;
    assign ex        = ex_reg;
    assign ey        = ey_reg;
    assign pa        = pa_reg;
    assign pb        = pb_reg;

endmodule

// ===== hw/rtl/tct_area.sv =====
// ----------------------------------------------------------------------------
// tct_area
// stages 2 and 3: edge-term products, then the three sub-areas and the
// whole area
// ----------------------------------------------------------------------------
module tct_area import tct_pkg::*;
#(
    parameter int COORD_FRAC_BITS = FRAC_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  tct_tag_t                               in_tag,
    input  logic signed [tct_pos_w(COORD_FRAC_BITS)-1:0] px,
    input  logic signed [tct_pos_w(COORD_FRAC_BITS)-1:0] py,
    input  logic signed [DIFF_W-1:0]               ex [LANES],
    input  logic signed [DIFF_W-1:0]               ey [LANES],
    input  logic signed [VPROD_W-1:0]              pa [LANES],
    input  logic signed [VPROD_W-1:0]              pb [LANES],
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output tct_tag_t                               out_tag,
    output logic signed [tct_sum_w(COORD_FRAC_BITS)-1:0] sub [LANES],
    output logic signed [W_W-1:0]                  whole
);

    localparam int MW = tct_mul_w(COORD_FRAC_BITS);
    localparam int SW = tct_sum_w(COORD_FRAC_BITS);

    logic                  v2_reg, v3_reg;
    logic                  ready2, ready3;
    tct_tag_t              tag2_reg, tag3_reg;
    logic signed [MW-1:0]  mx_reg [LANES];
    logic signed [MW-1:0]  my_reg [LANES];
    logic signed [K_W-1:0] k_reg  [LANES];
    logic signed [SW-1:0]  s_reg  [LANES];
    logic signed [W_W-1:0] w_reg;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                v2_reg <= in_valid;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 2: one multiplier per term
    always_ff @(posedge clk)
    begin
        if (ready2 && in_valid)
        begin
            tag2_reg <= in_tag;
            for (int i = 0; i < LANES; i++)
            begin
                mx_reg[i] <= MW'(px) * MW'(ex[i]);
                my_reg[i] <= MW'(py) * MW'(ey[i]);
                k_reg[i]  <= K_W'(pa[i]) - K_W'(pb[i]);
            end
        end
    end

    // stage 3: three-input sums
    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            tag3_reg <= tag2_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s_reg[i] <= SW'(mx_reg[i]) + SW'(my_reg[i]) + SW'(k_reg[i]);
            end
            w_reg <= W_W'(k_reg[0]) + W_W'(k_reg[1]) + W_W'(k_reg[2]);
        end
    end

    assign out_valid = v3_reg;
    assign out_tag   = tag3_reg;
    assign sub       = s_reg;
    assign whole     = w_reg;

endmodule

// ===== hw/rtl/tct_decide.sv =====
// ----------------------------------------------------------------------------
// tct_decide
// stage 4: barycentric range test on the three sub-areas, output register
// ----------------------------------------------------------------------------
module tct_decide import tct_pkg::*;
#(
    parameter int COORD_FRAC_BITS = FRAC_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  tct_tag_t                               in_tag,
    input  logic signed [tct_sum_w(COORD_FRAC_BITS)-1:0] sub [LANES],
    input  logic signed [W_W-1:0]                  whole,
    tct_out_if.source                              result
);

    localparam int SW = tct_sum_w(COORD_FRAC_BITS);

    logic                 v_reg;
    logic                 cov_reg;
    logic                 cov_next;
    logic [COL_W-1:0]     col_reg, row_reg;
    logic signed [SW-1:0] w_ext;
    logic                 w_pos;
    logic                 w_zero;
    logic [LANES-1:0]     lane_ok;

    assign w_ext  = SW'(whole);
    assign w_zero = (whole == '0);
    assign w_pos  = !whole[W_W-1] && !w_zero;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (w_pos)
            begin
                lane_ok[i] = !sub[i][SW-1] && (sub[i] <= w_ext);
            end
            else
            begin
                lane_ok[i] = (sub[i][SW-1] || (sub[i] == '0)) && (sub[i] >= w_ext);
            end
        end
        cov_next = in_tag.in_range && !w_zero && (&lane_ok);
    end

    assign in_ready = !v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            col_reg <= in_tag.col;
            row_reg <= in_tag.row;
            cov_reg <= cov_next;
        end
    end

    assign result.valid   = v_reg;
    assign result.out_col = col_reg;
    assign result.out_row = row_reg;
    assign result.covered = cov_reg;

endmodule
